[sv/aabb_frustum_cull_defines.svh]
// Assertion macros for the frustum culling RTL.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

`ifndef ASSERT_OFF
`define AFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFC_ASSERT(lbl, prop, msg)
`define AFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[sv/afc_pkg.sv]
// Shared types, widths and plane table for the frustum culling block.
`default_nettype none

package afc_pkg;

    localparam int COEF_BITS  = 32;
    localparam int COORD_BITS = 13;
    localparam int IDX_BITS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_PLANES = 5;
    localparam int HALF_EDGE  = 8;

    localparam int NW = COEF_BITS + 1;   // plane coefficient
    localparam int MW = COORD_BITS + 1;  // box center coordinate
    localparam int PW = NW + MW;         // one product
    localparam int EW = NW + 6;          // d + 8*(|nx|+|ny|+|nz|)
    localparam int AW = PW + 2;          // full plane sum

    localparam int IN_FIELDS_W = IDX_BITS + COEF_BITS + 3 * COORD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    localparam logic [1:0] ROW_W = 2'd3;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } t_func;

    typedef struct packed {
        logic                         vld;
        t_func                        func;
        logic [IDX_BITS-1:0]          idx;
        logic signed [COEF_BITS-1:0]  val;
        logic signed [MW-1:0]         mid_x;
        logic signed [MW-1:0]         mid_y;
        logic signed [MW-1:0]         mid_z;
        logic                         vis;
    } t_item;

    // left, right, bottom, top, near: row combined with row 3, and add/sub
    localparam logic [1:0] PLANE_ROW [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic       PLANE_SUB [NUM_PLANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

endpackage

`default_nettype wire

[sv/afc_cell.sv]
// One plane cell: keeps its matrix entries, tests a box against its plane.
`default_nettype none

module afc_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic [1:0]     i_row_k,
    input  wire logic           i_sub,
    input  wire afc_pkg::t_item i_item,
    output afc_pkg::t_item      o_item
);
    import afc_pkg::*;

    logic signed [COEF_BITS-1:0] r_hi [NUM_COLS];  // m(c,3)
    logic signed [COEF_BITS-1:0] r_lo [NUM_COLS];  // m(c,k)

    t_item r_it1, r_it2, r_it3;
    t_item n_it3;

    logic signed [NW-1:0] n_n [NUM_COLS];
    logic signed [NW-1:0] r_n [NUM_COLS];

    logic signed [PW-1:0] n_p [3];
    logic signed [PW-1:0] r_p [3];
    logic [NW-1:0]        w_abs [3];
    logic [NW+1:0]        w_abs_sum;
    logic signed [EW-1:0] n_ext;
    logic signed [EW-1:0] r_ext;
    logic signed [AW-1:0] w_acc;

    // entry copies; a load updates them when it passes through this cell
    always_ff @(posedge i_clk) begin
        if (i_en && i_item.vld && i_item.func == FUNC_LOAD) begin
            if (i_item.idx[1:0] == ROW_W) begin
                r_hi[i_item.idx[3:2]] <= i_item.val;
            end
            if (i_item.idx[1:0] == i_row_k) begin
                r_lo[i_item.idx[3:2]] <= i_item.val;
            end
        end
    end

    // stage 1: plane coefficients
    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            if (i_sub) begin
                n_n[c] = {r_hi[c][COEF_BITS-1], r_hi[c]} - {r_lo[c][COEF_BITS-1], r_lo[c]};
            end else begin
                n_n[c] = {r_hi[c][COEF_BITS-1], r_hi[c]} + {r_lo[c][COEF_BITS-1], r_lo[c]};
            end
        end
    end

    // stage 2: products and box extent
    always_comb begin
        n_p[0] = r_n[0] * r_it1.mid_x;
        n_p[1] = r_n[1] * r_it1.mid_y;
        n_p[2] = r_n[2] * r_it1.mid_z;
        for (int c = 0; c < 3; c++) begin
            w_abs[c] = r_n[c][NW-1] ? NW'(-r_n[c]) : NW'(r_n[c]);
        end
        w_abs_sum = (NW+2)'(w_abs[0]) + (NW+2)'(w_abs[1]) + (NW+2)'(w_abs[2]);
        n_ext = $signed({1'b0, w_abs_sum, 3'b000}) + EW'(r_n[3]);
    end

    // stage 3: sign of the plane sum
    always_comb begin
        w_acc = AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]) + AW'(r_ext);
        n_it3 = r_it2;
        if (r_it2.func == FUNC_TEST && w_acc[AW-1]) begin
            n_it3.vis = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it1.vld <= 1'b0;
            r_it2.vld <= 1'b0;
            r_it3.vld <= 1'b0;
        end else if (i_en) begin
            r_it1 <= i_item;
            r_it2 <= r_it1;
            r_it3 <= n_it3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_p   <= n_p;
            r_ext <= n_ext;
        end
    end

    assign o_item = r_it3;

endmodule

`default_nettype wire

[sv/afc_skid.sv]
// Output register with one skid entry; parts the result side from the cells.
`default_nettype none

`include "aabb_frustum_cull_defines.svh"

module afc_skid (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic i_vis,
    input  wire logic i_tready,
    output logic      o_tvalid,
    output logic      o_vis,
    output logic      o_ready
);
    import afc_pkg::*;

    logic r_out_vld, r_out;
    logic r_skid_vld, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_tready) begin
            r_out <= r_skid_vld ? r_skid : i_vis;
        end else if (i_push) begin
            r_skid <= i_vis;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_vis    = r_out;
    assign o_ready  = !r_skid_vld;

    `AFC_ASSERT(a_skid_behind_out, !r_skid_vld || r_out_vld, "skid full with output empty")
    `AFC_ASSERT(a_skid_fill_cause, !$rose(r_skid_vld) || $past(r_out_vld && !i_tready && i_push), "skid filled without a stalled push")
    `AFC_ASSERT_NXT(a_stall_to_skid, i_push && r_out_vld && !i_tready, r_skid_vld, "stalled result lost")

endmodule

`default_nettype wire

[sv/aabb_frustum_cull.sv]
// Top level: box-versus-frustum visibility test over a chain of plane cells.
//
// Input stream (s_axis): tuser[0] selects the item kind. A load transfer
// (tuser = 0) writes one 4x4 view-projection matrix entry (index = column*4 +
// row, signed Q16.16). A test transfer (tuser = 1) gives the minimum corner of
// a 16-unit cube; it yields one result transfer on m_axis, tdata[0] = visible.
// Loads yield nothing. Matrix entries are undefined after reset until loaded.
// Items run in order through five plane cells (left, right, bottom, top,
// near), three register stages each; a load updates each cell as it passes,
// so tests behind it see the new entry. One item is taken every cycle
// unless the chain is frozen (below). A test result passes through every
// cell stage, then the output register, before it shows on o_m_axis_tvalid.
// A result waiting on m_axis does not block the input: one skid entry
// catches the next result, and only when it is full does o_s_axis_tready
// drop, freezing the whole chain until the receiver takes a transfer.
// Reset (i_rst_n low, synchronous) empties the chain and the output.
`default_nettype none

module aabb_frustum_cull (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // entry_index, entry_value, offset_x, offset_y, offset_z, zero pad
    input  wire logic [afc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // func
    input  wire logic [0:0]                     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // visible, zero pad
    output logic [afc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import afc_pkg::*;

    localparam int VAL_LO = IDX_BITS;
    localparam int OX_LO  = VAL_LO + COEF_BITS;
    localparam int OY_LO  = OX_LO + COORD_BITS;
    localparam int OZ_LO  = OY_LO + COORD_BITS;

    t_item w_chain [NUM_PLANES+1];
    t_item w_tail;
    logic  w_en;
    logic  w_push;
    logic  w_vis;

    logic signed [COORD_BITS-1:0] w_ox, w_oy, w_oz;

    assign w_ox = i_s_axis_tdata[OX_LO +: COORD_BITS];
    assign w_oy = i_s_axis_tdata[OY_LO +: COORD_BITS];
    assign w_oz = i_s_axis_tdata[OZ_LO +: COORD_BITS];

    always_comb begin
        w_chain[0].vld   = i_s_axis_tvalid && w_en;
        w_chain[0].func  = t_func'(i_s_axis_tuser[0]);
        w_chain[0].idx   = i_s_axis_tdata[IDX_BITS-1:0];
        w_chain[0].val   = i_s_axis_tdata[VAL_LO +: COEF_BITS];
        w_chain[0].mid_x = MW'(w_ox) + MW'(HALF_EDGE);
        w_chain[0].mid_y = MW'(w_oy) + MW'(HALF_EDGE);
        w_chain[0].mid_z = MW'(w_oz) + MW'(HALF_EDGE);
        w_chain[0].vis   = 1'b1;
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        afc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_row_k (PLANE_ROW[g]),
            .i_sub   (PLANE_SUB[g]),
            .i_item  (w_chain[g]),
            .o_item  (w_chain[g+1])
        );
    end

    assign w_tail = w_chain[NUM_PLANES];
    assign w_push = w_en && w_tail.vld && w_tail.func == FUNC_TEST;

    afc_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_vis    (w_tail.vis),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_vis    (w_vis),
        .o_ready  (w_en)
    );

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tdata  = {(OUT_DATA_W-1)'(0), w_vis};

endmodule

`default_nettype wire
